>>> rtl/ble_alf_pkg.sv
// Shared types, constants and a helper function of the advertising accept-list filter.
`default_nettype none
package ble_alf_pkg;

	localparam int LIST_ENTRIES  = 4;
	localparam int NAME_BYTES    = 6;
	localparam int MAKER_MAX_LEN = 31;

	localparam int ADDR_W     = 48;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	typedef logic [2:0]  cfg_index_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef addr_t [LIST_ENTRIES-1:0] accept_list_t;

	// register indexes
	localparam cfg_index_t REG_ACCEPT_ADDR_0 = 3'd0;
	localparam cfg_index_t REG_NAME_REF      = 3'd4;
	localparam cfg_index_t REG_NAME_CHECK_EN = 3'd5;
	localparam cfg_index_t REG_LIST_CHECK_EN = 3'd6;

	// AD types of interest
	localparam logic [7:0] AD_SHORT_NAME    = 8'h08;
	localparam logic [7:0] AD_COMPLETE_NAME = 8'h09;
	localparam logic [7:0] AD_MAKER_DATA    = 8'hFF;

	// address match modes
	localparam logic [2:0] MODE_NONE        = 3'd0;
	localparam logic [2:0] MODE_FULL_NORMAL = 3'd1;
	localparam logic [2:0] MODE_FULL_REV    = 3'd2;
	localparam logic [2:0] MODE_SUFFIX_NORM = 3'd3;
	localparam logic [2:0] MODE_SUFFIX_REV  = 3'd4;

	// match reasons
	localparam logic [1:0] REASON_NONE      = 2'd0;
	localparam logic [1:0] REASON_NAME      = 2'd1;
	localparam logic [1:0] REASON_ADDR      = 2'd2;
	localparam logic [1:0] REASON_NAME_ADDR = 2'd3;

	// one finished packet handed from parser to matcher
	typedef struct packed {
		addr_t      addr;
		logic       name_ok;
		logic       maker_hit;
		logic [7:0] maker_start;
		logic [4:0] maker_size;
	} pkt_rec_t;

	function automatic logic [2:0] addr_mode(input addr_t a, input addr_t r);
		logic [5:0][7:0] ab;
		logic [5:0][7:0] rb;
		logic            rev;
		ab  = a;
		rb  = r;
		rev = 1'b1;
		for (int k = 0; k < 6; k++) begin
			if (ab[k] != rb[5-k]) rev = 1'b0;
		end
		if (a == r)
			return MODE_FULL_NORMAL;
		else if (rev)
			return MODE_FULL_REV;
		else if (ab[3] == rb[3] && ab[4] == rb[4] && ab[5] == rb[5])
			return MODE_SUFFIX_NORM;
		else if (ab[2] == rb[3] && ab[1] == rb[4] && ab[0] == rb[5])
			return MODE_SUFFIX_REV;
		else
			return MODE_NONE;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ble_alf_parser.sv
// Front end: walks the AD fields of each payload byte and emits one record per packet.
`default_nettype none
module ble_alf_parser (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     byte_accept,
	input  wire [7:0]               payload_byte,
	input  wire                     last_byte,
	input  wire [47:0]              sender_address,
	input  wire [47:0]              name_ref,
	input  wire                     name_check_enable,
	output logic                    rec_push,
	output ble_alf_pkg::pkt_rec_t   rec
);
	import ble_alf_pkg::*;

	logic [7:0] bp_q, nfs_q, flen_q, ftype_q, mstart_q;
	logic       stop_q, neq_q, nhit_q, mhit_q;
	logic [4:0] msize_q;

	logic [7:0] bp_n, nfs_n, flen_n, ftype_n, mstart_n;
	logic       stop_n, neq_n, nhit_n, mhit_n;
	logic [4:0] msize_n;

	logic [7:0][7:0] tn_bytes;
	logic [7:0]      kb, typ, dlen, dclip;
	logic            eq;
	logic [8:0]      off9;
	logic [9:0]      next10;

	assign tn_bytes = {16'h0000, name_ref};
	assign kb       = bp_q - nfs_q - 8'd2;

	always_comb begin
		bp_n     = bp_q;
		nfs_n    = nfs_q;
		flen_n   = flen_q;
		ftype_n  = ftype_q;
		stop_n   = stop_q;
		neq_n    = neq_q;
		nhit_n   = nhit_q;
		mhit_n   = mhit_q;
		mstart_n = mstart_q;
		msize_n  = msize_q;
		typ      = ({1'b0, bp_q} == {1'b0, nfs_q} + 9'd1) ? payload_byte : ftype_q;
		eq       = ({1'b0, bp_q} == {1'b0, nfs_q} + 9'd1) ? 1'b1 :
		           (neq_q & ~(kb < 8'(NAME_BYTES) && payload_byte != tn_bytes[kb[2:0]]));
		dlen     = flen_q - 8'd1;
		dclip    = (dlen > 8'(MAKER_MAX_LEN)) ? 8'(MAKER_MAX_LEN) : dlen;
		off9     = {1'b0, nfs_q} + 9'd2;
		next10   = {2'b00, nfs_q} + {2'b00, flen_q} + 10'd1;

		if (!stop_q && bp_q >= nfs_q) begin
			if (bp_q == nfs_q) begin
				if (payload_byte == 8'd0) stop_n = 1'b1;
				else flen_n = payload_byte;
			end else begin
				ftype_n = typ;
				neq_n   = eq;
				// last byte of the field
				if ({1'b0, bp_q} == {1'b0, nfs_q} + {1'b0, flen_q}) begin
					if ((typ == AD_SHORT_NAME || typ == AD_COMPLETE_NAME) &&
					    dlen == 8'(NAME_BYTES) && eq)
						nhit_n = 1'b1;
					if (typ == AD_MAKER_DATA && !mhit_q) begin
						mhit_n   = 1'b1;
						mstart_n = off9[8] ? 8'hFF : off9[7:0];
						msize_n  = dclip[4:0];
					end
					if (next10 > 10'd255) stop_n = 1'b1;
					else nfs_n = next10[7:0];
				end
			end
		end

		rec.addr        = sender_address;
		rec.name_ok     = name_check_enable & nhit_n;
		rec.maker_hit   = mhit_n;
		rec.maker_start = mhit_n ? mstart_n : 8'd0;
		rec.maker_size  = mhit_n ? msize_n : 5'd0;
		rec_push        = byte_accept & last_byte;

		if (last_byte) begin
			bp_n     = 8'd0;
			nfs_n    = 8'd0;
			flen_n   = 8'd0;
			ftype_n  = 8'd0;
			stop_n   = 1'b0;
			neq_n    = 1'b0;
			nhit_n   = 1'b0;
			mhit_n   = 1'b0;
			mstart_n = 8'd0;
			msize_n  = 5'd0;
		end else if (bp_q == 8'hFF) begin
			stop_n = 1'b1;
		end else begin
			bp_n = bp_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q     <= 8'd0;
			nfs_q    <= 8'd0;
			flen_q   <= 8'd0;
			ftype_q  <= 8'd0;
			stop_q   <= 1'b0;
			neq_q    <= 1'b0;
			nhit_q   <= 1'b0;
			mhit_q   <= 1'b0;
			mstart_q <= 8'd0;
			msize_q  <= 5'd0;
		end else if (byte_accept) begin
			bp_q     <= bp_n;
			nfs_q    <= nfs_n;
			flen_q   <= flen_n;
			ftype_q  <= ftype_n;
			stop_q   <= stop_n;
			neq_q    <= neq_n;
			nhit_q   <= nhit_n;
			mhit_q   <= mhit_n;
			mstart_q <= mstart_n;
			msize_q  <= msize_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ble_alf_queue.sv
// Two-entry queue of packet records between parser and matcher.
`default_nettype none
module ble_alf_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  ble_alf_pkg::pkt_rec_t   push_rec,
	input  wire                     pop,
	output logic                    full,
	output logic                    not_empty,
	output ble_alf_pkg::pkt_rec_t   head
);
	import ble_alf_pkg::*;

	pkt_rec_t   mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

>>> rtl/ble_alf_matcher.sv
// Back end: checks the address against the accept list and holds the verdict for the receiver.
`default_nettype none
module ble_alf_matcher (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  rec_valid,
	input  ble_alf_pkg::pkt_rec_t                rec,
	output logic                                 rec_pop,
	input  ble_alf_pkg::accept_list_t            accept_addr,
	input  wire                                  list_check_enable,
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [ble_alf_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import ble_alf_pkg::*;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [2:0]            mode, m;
	logic [1:0]            entry, reason;

	// first enabled entry with any mode wins
	always_comb begin
		mode  = MODE_NONE;
		entry = 2'd0;
		m     = MODE_NONE;
		if (list_check_enable) begin
			for (int i = LIST_ENTRIES - 1; i >= 0; i--) begin
				m = addr_mode(rec.addr, accept_addr[i]);
				if (accept_addr[i] != 48'd0 && m != MODE_NONE) begin
					mode  = m;
					entry = 2'(i);
				end
			end
		end
		if (mode != MODE_NONE) reason = rec.name_ok ? REASON_NAME_ADDR : REASON_ADDR;
		else reason = rec.name_ok ? REASON_NAME : REASON_NONE;
	end

	assign rec_pop       = rec_valid & (~out_valid_q | m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk) begin
		if (rec_pop)
			out_data_q <= {1'b0, rec.maker_size, rec.maker_start, rec.maker_hit, rec.name_ok,
			               mode, entry, reason, (mode != MODE_NONE)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (rec_pop) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

endmodule
`default_nettype wire

>>> rtl/ble_adv_accept_list_filter_top.sv
// Top level of the advertising accept-list filter: config registers, parser, queue, matcher.
//
// Input stream (s_axis): one advertising payload byte per item, with the sender
// address alongside; tlast marks the final byte of a packet. Bytes may stream
// back to back at one per clock while the record queue is not full.
// Output stream (m_axis): one verdict item per packet, produced from the final byte.
// The parser (front end) updates its field-walk registers on each byte and, on
// the final byte, drops a packet record into a two-entry queue. The matcher (back
// end) compares the address with all accept-list entries in parallel and loads an
// output register as it pops the record, and m_axis_tvalid is driven from that register.
// Sustained rate: one byte per cycle while the queue has room, one verdict per cycle at most.
// Receiver stall: the output register holds its item; the matcher stops draining
// the queue, and s_axis_tready drops only once the queue holds two records.
// Config (cfg_*): cfg_ready is always high; a write with an unused index is dropped.
// Write registers only while no packet is in flight.
// Reset: config returns to zero addresses, zero name, both checks enabled; the
// parser, queue and output register are empty. No clearing pass is needed.
`default_nettype none
module ble_adv_accept_list_filter_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [47:0] sender_address, [55:48] payload_byte
	input  wire  [ble_alf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  wire                                  s_axis_tlast,     // last_byte
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// [0] is_target, [2:1] reason, [4:3] entry_index, [7:5] address_match_mode,
	// [8] name_seen, [9] maker_found, [17:10] maker_offset, [22:18] maker_length
	output logic [ble_alf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [2:0]                           cfg_index,
	input  wire  [47:0]                          cfg_data
);
	import ble_alf_pkg::*;

	accept_list_t accept_addr_q;
	logic [47:0]  name_ref_q;
	logic         name_check_en_q;
	logic         list_check_en_q;

	logic         cfg_we;
	logic         byte_accept;
	logic         rec_push, rec_pop, q_full, q_not_empty;
	pkt_rec_t     push_rec, head_rec;

	assign cfg_ready   = 1'b1;
	assign cfg_we      = cfg_valid & cfg_ready;
	assign byte_accept = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = ~q_full;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_addr_q   <= '0;
			name_ref_q      <= 48'd0;
			name_check_en_q <= 1'b1;
			list_check_en_q <= 1'b1;
		end else if (cfg_we) begin
			for (int i = 0; i < LIST_ENTRIES; i++) begin
				if (cfg_index == REG_ACCEPT_ADDR_0 + 3'(i)) accept_addr_q[i] <= cfg_data;
			end
			case (cfg_index)
				REG_NAME_REF:      name_ref_q      <= cfg_data;
				REG_NAME_CHECK_EN: name_check_en_q <= cfg_data[0];
				REG_LIST_CHECK_EN: list_check_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ble_alf_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_accept       (byte_accept),
		.payload_byte      (s_axis_tdata[55:48]),
		.last_byte         (s_axis_tlast),
		.sender_address    (s_axis_tdata[47:0]),
		.name_ref          (name_ref_q),
		.name_check_enable (name_check_en_q),
		.rec_push          (rec_push),
		.rec               (push_rec)
	);

	ble_alf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_rec  (push_rec),
		.pop       (rec_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_rec)
	);

	ble_alf_matcher u_matcher (
		.clk               (clk),
		.arst_n            (arst_n),
		.rec_valid         (q_not_empty),
		.rec               (head_rec),
		.rec_pop           (rec_pop),
		.accept_addr       (accept_addr_q),
		.list_check_enable (list_check_en_q),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.m_axis_tdata      (m_axis_tdata)
	);

endmodule
`default_nettype wire
